FILE: hw/rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent, checked at every rising edge outside reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
    else $error("assertion failed: implication");

// expression must never hold outside reset
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("assertion failed: forbidden condition");

`endif

FILE: hw/rtl/imgup_pkg.sv
// package: types, constants and helpers of the image upscale sampler
`default_nettype none

package imgup_pkg;

  // default sizes
  localparam int DEF_MAX_WIDTH      = 64;
  localparam int DEF_MAX_HEIGHT     = 64;
  localparam int DEF_MAX_SCALE_LOG2 = 3;
  localparam int DEF_GAIN_FRAC_BITS = 10;

  // fixed field widths
  localparam int COORD_W     = 9;
  localparam int PIXEL_W     = 8;
  localparam int INTENSITY_W = 17;
  localparam int GAIN_W      = 12;
  localparam int DIM_REG_W   = 7;
  localparam int SCALE_REG_W = 2;
  localparam int CFG_DATA_W  = 12;
  localparam int CFG_INDEX_W = 3;
  // holds any image dimension up to 1024
  localparam int DIM_W       = 11;

  localparam logic [INTENSITY_W-1:0] INTENSITY_MAX = '1;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SCALE_LOG2     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_MODE    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_WIDTH   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_HEIGHT  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_INTENSITY_GAIN = 3'd4;

  // action and mode codes
  localparam logic ACT_WRITE     = 1'b0;
  localparam logic ACT_SAMPLE    = 1'b1;
  localparam logic MODE_NEAREST  = 1'b0;
  localparam logic MODE_BILINEAR = 1'b1;

  // reset values of the registers
  localparam logic [DIM_REG_W-1:0] RST_SOURCE_DIM = 7'd64;
  localparam logic [GAIN_W-1:0]    RST_GAIN       = 12'd1024;

  // neighbour taps in fetch order
  typedef enum logic [1:0] {
    TAP_00,
    TAP_10,
    TAP_01,
    TAP_11
  } tap_t;

  typedef struct packed {
    logic               action;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic [PIXEL_W-1:0] pixel_value;
  } sample_req_t;

  typedef struct packed {
    logic [COORD_W-1:0]     sample_x;
    logic [COORD_W-1:0]     sample_y;
    logic [INTENSITY_W-1:0] intensity;
  } sample_res_t;

  // datapath control from the sequencer
  typedef struct packed {
    logic clear;
    logic accum;
    logic gain_load;
    logic out_load;
  } mac_ctrl_t;

  // register value 0 acts as 1, anything above the maximum as the maximum
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_REG_W-1:0] r,
                                               input logic [DIM_W-1:0] maxd);
    logic [DIM_W-1:0] ext;
    ext = DIM_W'(r);
    if (r == '0) begin
      return DIM_W'(1);
    end
    return (ext > maxd) ? maxd : ext;
  endfunction

  // clamp an index to the last valid position below lim
  function automatic logic [DIM_W-1:0] clamp_index(input logic [DIM_W-2:0] v,
                                                   input logic [DIM_W-1:0] lim);
    logic [DIM_W-1:0] ext;
    ext = {1'b0, v};
    return (ext >= lim) ? lim - DIM_W'(1) : ext;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/imgup_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none

module imgup_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [DATA_W-1:0]        wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/imgup_tap.sv
// neighbour address and bilinear weight for one fetch tap
`default_nettype none

module imgup_tap
  import imgup_pkg::*;
#(
  parameter int MAX_WIDTH      = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT     = DEF_MAX_HEIGHT,
  parameter int MAX_SCALE_LOG2 = DEF_MAX_SCALE_LOG2
) (
  input  wire tap_t                                         tap,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]                 x0,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]                 x1,
  input  wire logic [$clog2(MAX_HEIGHT)-1:0]                y0,
  input  wire logic [$clog2(MAX_HEIGHT)-1:0]                y1,
  input  wire logic [MAX_SCALE_LOG2:0]                      wx0,
  input  wire logic [MAX_SCALE_LOG2:0]                      wx1,
  input  wire logic [MAX_SCALE_LOG2:0]                      wy0,
  input  wire logic [MAX_SCALE_LOG2:0]                      wy1,
  output logic      [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]      addr,
  output logic      [2*MAX_SCALE_LOG2:0]                    weight
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int FW = MAX_SCALE_LOG2;

  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [FW:0]   wx;
  logic [FW:0]   wy;

  always_comb begin
    case (tap)
      TAP_00: begin
        col = x0; row = y0; wx = wx0; wy = wy0;
      end
      TAP_10: begin
        col = x1; row = y0; wx = wx1; wy = wy0;
      end
      TAP_01: begin
        col = x0; row = y1; wx = wx0; wy = wy1;
      end
      TAP_11: begin
        col = x1; row = y1; wx = wx1; wy = wy1;
      end
      default: begin
        col = x0; row = y0; wx = wx0; wy = wy0;
      end
    endcase
  end

  // row-major store layout
  assign addr   = AW'(32'(row) * MAX_WIDTH + 32'(col));
  assign weight = {{FW{1'b0}}, wx} * {{FW{1'b0}}, wy};

endmodule

`default_nettype wire

FILE: hw/rtl/imgup_mac.sv
// weighted neighbour accumulator, gain multiply and rounding
`default_nettype none

module imgup_mac
  import imgup_pkg::*;
#(
  parameter int MAX_SCALE_LOG2 = DEF_MAX_SCALE_LOG2,
  parameter int GAIN_FRAC_BITS = DEF_GAIN_FRAC_BITS
) (
  input  wire logic                                   clk,
  input  wire mac_ctrl_t                              ctrl,
  input  wire logic [PIXEL_W-1:0]                     pixel,
  input  wire logic [2*MAX_SCALE_LOG2:0]              weight,
  input  wire logic [GAIN_W-1:0]                      gain,
  input  wire logic [$clog2(MAX_SCALE_LOG2+1)-1:0]    scale,
  output logic      [INTENSITY_W-1:0]                 intensity
);

  localparam int ACC_W = PIXEL_W + 2 * MAX_SCALE_LOG2;
  localparam int PW    = ACC_W + GAIN_W;
  localparam int NUM_W = PW + 8 + 1;
  localparam int TW    = $clog2(2 * MAX_SCALE_LOG2 + GAIN_FRAC_BITS + 1);

  logic [ACC_W-1:0] acc;
  logic [ACC_W-1:0] contrib;
  logic [PW-1:0]    prod;
  logic [TW-1:0]    shift;
  logic [NUM_W-1:0] num;
  logic [NUM_W-1:0] val;

  // zero-weight taps add nothing, whatever the store returns
  assign contrib = (weight == '0) ? '0 : ACC_W'(pixel) * ACC_W'(weight);

  // t = 2s + frac bits, result in 1/256 units rounded half up
  assign shift = TW'({scale, 1'b0}) + TW'(GAIN_FRAC_BITS);
  assign num   = {1'b0, prod, 8'b0} + (NUM_W'(1) << (shift - TW'(1)));
  assign val   = num >> shift;

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc <= '0;
    end else if (ctrl.accum) begin
      acc <= acc + contrib;
    end
    if (ctrl.gain_load) begin
      prod <= PW'(acc) * PW'(gain);
    end
    if (ctrl.out_load) begin
      intensity <= (val > NUM_W'(INTENSITY_MAX)) ? INTENSITY_MAX : val[INTENSITY_W-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/image_upscale_sampler.sv
// top level of the image upscale sampler: store, fetch sequencer, config registers
//
//   channel   direction  handshake                     payload
//   command   in         start high while busy low     req (sample_req_t)
//   result    out        done strobe, one cycle        result (sample_res_t)
//   config    in         cfg_we, write at the edge     cfg_index, cfg_data
//
// a write transaction never raises busy; writes may come back to back.
// a sample transaction holds busy through the fetch, drain, gain and round
// states, done high in the cycle right after the last busy cycle; the
// neighbour fetch through the single read port of the pixel store sets the length
// of the fetch state (one read per tap, four taps for bilinear).
// reset clears the sequencer and the registers; the pixel store is not
// cleared and holds whatever was last written.
// the result receiver cannot stall, so the result is shown exactly once.
`default_nettype none
`include "assert_macros.svh"

module image_upscale_sampler
  import imgup_pkg::*;
#(
  parameter int MAX_WIDTH      = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT     = DEF_MAX_HEIGHT,
  parameter int MAX_SCALE_LOG2 = DEF_MAX_SCALE_LOG2,
  parameter int GAIN_FRAC_BITS = DEF_GAIN_FRAC_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // command transaction
  input  wire logic                   start,
  output logic                        busy,
  input  wire sample_req_t            req,
  // result transaction
  output logic                        done,
  output sample_res_t                 result,
  // register writes
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int SW = $clog2(MAX_SCALE_LOG2 + 1);
  localparam int FW = MAX_SCALE_LOG2;
  localparam int WW = 2 * MAX_SCALE_LOG2 + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DRAIN,
    ST_GAIN,
    ST_ROUND
  } state_t;

  // configuration registers
  logic [SCALE_REG_W-1:0] scale_log2;
  logic                   sample_mode;
  logic [DIM_REG_W-1:0]   source_width;
  logic [DIM_REG_W-1:0]   source_height;
  logic [GAIN_W-1:0]      intensity_gain;

  // sequencer
  state_t state;
  tap_t   tap;
  logic   rd_valid;

  // latched sample job
  logic [CW-1:0]      job_x0;
  logic [CW-1:0]      job_x1;
  logic [RW-1:0]      job_y0;
  logic [RW-1:0]      job_y1;
  logic [FW:0]        job_wx0;
  logic [FW:0]        job_wx1;
  logic [FW:0]        job_wy0;
  logic [FW:0]        job_wy1;
  logic [SW-1:0]      job_scale;
  logic               job_mode;
  logic [COORD_W-1:0] job_cx;
  logic [COORD_W-1:0] job_cy;
  logic [WW-1:0]      weight_q;

  // decode of the incoming command
  logic [DIM_W-1:0]   eff_w;
  logic [DIM_W-1:0]   eff_h;
  logic [SW-1:0]      s_eff;
  logic [FW-1:0]      frac_mask;
  logic [FW-1:0]      frac_x;
  logic [FW-1:0]      frac_y;
  logic [FW:0]        span;
  logic [FW:0]        wx1_next;
  logic [FW:0]        wy1_next;
  logic [COORD_W-1:0] src_x;
  logic [COORD_W-1:0] src_y;
  logic               accept;
  logic               accept_sample;
  logic               wr_en;
  logic               wr_in_range;
  logic [AW-1:0]      waddr;

  // fetch and datapath
  logic [AW-1:0]      raddr;
  logic [WW-1:0]      tap_weight;
  logic [PIXEL_W-1:0] rdata;
  logic [INTENSITY_W-1:0] intensity;
  mac_ctrl_t          mac_ctrl;
  tap_t               last_tap;

  assign busy          = (state != ST_IDLE);
  assign accept        = start && !busy;
  assign accept_sample = accept && (req.action == ACT_SAMPLE);

  assign eff_w = eff_dim(source_width, DIM_W'(MAX_WIDTH));
  assign eff_h = eff_dim(source_height, DIM_W'(MAX_HEIGHT));

  // scale saturates at the largest supported factor
  assign s_eff = (32'(scale_log2) > MAX_SCALE_LOG2) ? SW'(MAX_SCALE_LOG2) : SW'(scale_log2);

  // fraction is the low s bits of the output coordinate
  assign frac_mask = ~({FW{1'b1}} << s_eff);
  assign frac_x    = req.coord_x[FW-1:0] & frac_mask;
  assign frac_y    = req.coord_y[FW-1:0] & frac_mask;
  assign span      = {{FW{1'b0}}, 1'b1} << s_eff;
  // nearest mode puts the full S*S weight on the floored pixel
  assign wx1_next  = (sample_mode == MODE_BILINEAR) ? {1'b0, frac_x} : '0;
  assign wy1_next  = (sample_mode == MODE_BILINEAR) ? {1'b0, frac_y} : '0;
  assign src_x     = req.coord_x >> s_eff;
  assign src_y     = req.coord_y >> s_eff;

  // pixel load path, writes outside the image are dropped
  assign wr_in_range = ({2'b0, req.coord_x} < eff_w) && ({2'b0, req.coord_y} < eff_h);
  assign wr_en       = accept && (req.action == ACT_WRITE) && wr_in_range;
  assign waddr       = AW'(32'(req.coord_y) * MAX_WIDTH + 32'(req.coord_x));

  assign last_tap = (job_mode == MODE_BILINEAR) ? TAP_11 : TAP_00;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_log2     <= '0;
      sample_mode    <= MODE_NEAREST;
      source_width   <= RST_SOURCE_DIM;
      source_height  <= RST_SOURCE_DIM;
      intensity_gain <= RST_GAIN;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCALE_LOG2:     scale_log2     <= cfg_data[SCALE_REG_W-1:0];
        REG_SAMPLE_MODE:    sample_mode    <= cfg_data[0];
        REG_SOURCE_WIDTH:   source_width   <= cfg_data[DIM_REG_W-1:0];
        REG_SOURCE_HEIGHT:  source_height  <= cfg_data[DIM_REG_W-1:0];
        REG_INTENSITY_GAIN: intensity_gain <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer: one store read per tap, then drain, gain and round
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      tap      <= TAP_00;
      rd_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      rd_valid <= 1'b0;
      done     <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept_sample) begin
            state     <= ST_FETCH;
            tap       <= TAP_00;
            job_x0    <= CW'(clamp_index({1'b0, src_x}, eff_w));
            job_x1    <= CW'(clamp_index({1'b0, src_x} + 10'd1, eff_w));
            job_y0    <= RW'(clamp_index({1'b0, src_y}, eff_h));
            job_y1    <= RW'(clamp_index({1'b0, src_y} + 10'd1, eff_h));
            job_wx0   <= span - wx1_next;
            job_wx1   <= wx1_next;
            job_wy0   <= span - wy1_next;
            job_wy1   <= wy1_next;
            job_scale <= s_eff;
            job_mode  <= sample_mode;
            job_cx    <= req.coord_x;
            job_cy    <= req.coord_y;
          end
        end
        ST_FETCH: begin
          rd_valid <= 1'b1;
          weight_q <= tap_weight;
          if (tap == last_tap) begin
            state <= ST_DRAIN;
          end else begin
            tap <= tap_t'(tap + 2'd1);
          end
        end
        ST_DRAIN: begin
          state <= ST_GAIN;
        end
        ST_GAIN: begin
          state <= ST_ROUND;
        end
        ST_ROUND: begin
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  imgup_tap #(
    .MAX_WIDTH      (MAX_WIDTH),
    .MAX_HEIGHT     (MAX_HEIGHT),
    .MAX_SCALE_LOG2 (MAX_SCALE_LOG2)
  ) u_tap (
    .tap    (tap),
    .x0     (job_x0),
    .x1     (job_x1),
    .y0     (job_y0),
    .y1     (job_y1),
    .wx0    (job_wx0),
    .wx1    (job_wx1),
    .wy0    (job_wy0),
    .wy1    (job_wy1),
    .addr   (raddr),
    .weight (tap_weight)
  );

  // source image, row-major
  imgup_ram #(
    .DATA_W (PIXEL_W),
    .DEPTH  (MAX_WIDTH * MAX_HEIGHT)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (waddr),
    .wdata (req.pixel_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  // read data arrives in the cycle after the tap is issued, together with weight_q
  assign mac_ctrl.clear     = accept_sample;
  assign mac_ctrl.accum     = rd_valid;
  assign mac_ctrl.gain_load = (state == ST_GAIN);
  assign mac_ctrl.out_load  = (state == ST_ROUND);

  imgup_mac #(
    .MAX_SCALE_LOG2 (MAX_SCALE_LOG2),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_mac (
    .clk       (clk),
    .ctrl      (mac_ctrl),
    .pixel     (rdata),
    .weight    (weight_q),
    .gain      (intensity_gain),
    .scale     (job_scale),
    .intensity (intensity)
  );

  assign result.sample_x  = job_cx;
  assign result.sample_y  = job_cy;
  assign result.intensity = intensity;

  // fixed latency per mode
  `ASSERT_IMPLY(a_nearest_latency, clk, rst,
    accept_sample && (sample_mode == MODE_NEAREST), ##5 done)
  `ASSERT_IMPLY(a_bilinear_latency, clk, rst,
    accept_sample && (sample_mode == MODE_BILINEAR), ##8 done)
  // no store read in flight once the sequencer is idle
  `ASSERT_IMPLY(a_idle_no_read, clk, rst, !busy, !rd_valid)
  // the result strobe comes only after the sequencer has released busy
  `ASSERT_NEVER(a_done_while_busy, clk, rst, done && busy)

endmodule

`default_nettype wire

FILE: verif/tb.sv
// testbench for image_upscale_sampler: directed table, then random image phases against a predictor
module tb;
  import imgup_pkg::*;

  // run sizing
  localparam int ITEM_TARGET   = 1350;
  localparam int CYCLE_LIMIT   = 400000;
  // cycles to let the block settle once nothing is pending
  localparam int SETTLE_CYCLES = 12;
  localparam int REPORT_LIMIT  = 10;
  // index with no register behind it, writes there must change nothing
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  sample_req_t            req = '0;
  logic                   done;
  sample_res_t            result;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  image_upscale_sampler uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------
  // predictor state: register mirror and a copy of the pixel store
  // ---------------------------------------------------------------
  logic [SCALE_REG_W-1:0] scale_cfg  = '0;
  logic                   mode_cfg   = MODE_NEAREST;
  logic [DIM_REG_W-1:0]   width_cfg  = RST_SOURCE_DIM;
  logic [DIM_REG_W-1:0]   height_cfg = RST_SOURCE_DIM;
  logic [GAIN_W-1:0]      gain_cfg   = RST_GAIN;
  logic [PIXEL_W-1:0]     pix_mem [DEF_MAX_WIDTH*DEF_MAX_HEIGHT];

  // samples accepted whose result has not come back yet, oldest first
  sample_res_t pending_samples [$];

  int  mismatches = 0;
  int  cycles = 0;
  int  item_total = 0;
  bit  took = 1'b0;      // set by the monitor when the command transaction is taken
  int  burst_left = 0;
  bit  steady = 1'b0;    // phases with no gaps between transactions

  // 0 acts as 1, anything above the maximum as the maximum
  function automatic int unsigned eff_span(input logic [DIM_REG_W-1:0] r,
                                           input int unsigned maxd);
    if (r == '0) begin
      return 1;
    end
    return (r > maxd) ? maxd : r;
  endfunction

  function automatic longint unsigned src_pix(input int unsigned col, input int unsigned row);
    return longint'(pix_mem[row*DEF_MAX_WIDTH + col]);
  endfunction

  // expected result of a sample transaction under the current register mirror
  function automatic sample_res_t upscale_predict(input sample_req_t c);
    int unsigned       s, sz, w, h, a, b, sx, sy, x0, y0, x1, y1, t;
    longint unsigned   acc, scaled;
    sample_res_t       res;
    s = scale_cfg;
    if (s > DEF_MAX_SCALE_LOG2) begin
      s = DEF_MAX_SCALE_LOG2;
    end
    sz = 1 << s;
    w  = eff_span(width_cfg, DEF_MAX_WIDTH);
    h  = eff_span(height_cfg, DEF_MAX_HEIGHT);
    a  = c.coord_x & (sz - 1);
    b  = c.coord_y & (sz - 1);
    sx = c.coord_x >> s;
    sy = c.coord_y >> s;
    // neighbours clamp to the last column and row
    x0 = (sx >= w) ? w - 1 : sx;
    y0 = (sy >= h) ? h - 1 : sy;
    x1 = (sx + 1 >= w) ? w - 1 : sx + 1;
    y1 = (sy + 1 >= h) ? h - 1 : sy + 1;
    if (mode_cfg == MODE_NEAREST) begin
      acc = src_pix(x0, y0) * sz * sz;
    end else begin
      acc = src_pix(x0, y0) * (sz - a) * (sz - b)
          + src_pix(x1, y0) * a * (sz - b)
          + src_pix(x0, y1) * (sz - a) * b
          + src_pix(x1, y1) * a * b;
    end
    // gain, scale to 1/256 levels, round half up, saturate
    t = 2 * s + DEF_GAIN_FRAC_BITS;
    scaled = ((acc * gain_cfg) << 8) + (64'd1 << (t - 1));
    scaled = scaled >> t;
    res.sample_x  = c.coord_x;
    res.sample_y  = c.coord_y;
    res.intensity = (scaled > INTENSITY_MAX) ? INTENSITY_MAX : scaled[INTENSITY_W-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------
  task automatic flag(input string what, input longint unsigned want_v,
                      input longint unsigned got_v);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("mismatch on %s: expected %0d, got %0d", what, want_v, got_v);
    end
  endtask

  task automatic check_result(input sample_res_t got);
    sample_res_t want_r;
    if (pending_samples.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
        $display("result with nothing pending: x %0d y %0d intensity %0d",
                 got.sample_x, got.sample_y, got.intensity);
      end
    end else begin
      want_r = pending_samples.pop_front();
      if (got.sample_x !== want_r.sample_x) begin
        flag("sample_x", want_r.sample_x, got.sample_x);
      end
      if (got.sample_y !== want_r.sample_y) begin
        flag("sample_y", want_r.sample_y, got.sample_y);
      end
      if (got.intensity !== want_r.intensity) begin
        flag("intensity", want_r.intensity, got.intensity);
      end
    end
  endtask

  // monitor: handshakes seen at the rising edge, before the block updates
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        took = 1'b1;
      end
      if (done) begin
        check_result(result);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------
  // driving: everything changes at the falling edge
  // ---------------------------------------------------------------

  // one register write; the enable drops in the following cycle
  task automatic cfg_put(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    case (idx)
      REG_SCALE_LOG2:     scale_cfg  = d[SCALE_REG_W-1:0];
      REG_SAMPLE_MODE:    mode_cfg   = d[0];
      REG_SOURCE_WIDTH:   width_cfg  = d[DIM_REG_W-1:0];
      REG_SOURCE_HEIGHT:  height_cfg = d[DIM_REG_W-1:0];
      REG_INTENSITY_GAIN: gain_cfg   = d[GAIN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // stop sending, wait for every pending result, then let the block settle
  task automatic quiesce();
    start <= 1'b0;
    while (pending_samples.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // one command transaction; a typed expectation replaces the predicted intensity
  task automatic issue(input sample_req_t c, input bit typed,
                       input logic [INTENSITY_W-1:0] want);
    int unsigned gap;
    sample_res_t res;
    // sender works in bursts with random gaps between them
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    req   <= c;
    took  = 1'b0;
    @(negedge clk);
    while (!took) begin
      @(negedge clk);
    end
    // taken at the last rising edge: update the predictor in order
    if (c.action == ACT_WRITE) begin
      if (c.coord_x < eff_span(width_cfg, DEF_MAX_WIDTH) &&
          c.coord_y < eff_span(height_cfg, DEF_MAX_HEIGHT)) begin
        pix_mem[c.coord_y*DEF_MAX_WIDTH + c.coord_x] = c.pixel_value;
      end
    end else begin
      res = upscale_predict(c);
      if (typed) begin
        res.intensity = want;
      end
      pending_samples.push_back(res);
    end
  endtask

  // ---------------------------------------------------------------
  // directed table
  // ---------------------------------------------------------------
  typedef enum logic {ROW_REG, ROW_ITEM} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic [CFG_INDEX_W-1:0] idx;
    logic [CFG_DATA_W-1:0]  data;
    sample_req_t            cmd;
    bit                     typed;
    logic [INTENSITY_W-1:0] want;
  } stim_row_t;

  stim_row_t dir_tab [$];

  function automatic stim_row_t reg_row(input logic [CFG_INDEX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] d);
    stim_row_t r;
    r = '{kind: ROW_REG, idx: idx, data: d, cmd: '0, typed: 1'b0, want: '0};
    return r;
  endfunction

  function automatic stim_row_t item_row(input logic act, input int unsigned x,
                                         input int unsigned y, input int unsigned v);
    stim_row_t r;
    r = '{kind: ROW_ITEM, idx: '0, data: '0, cmd: '0, typed: 1'b0, want: '0};
    r.cmd.action      = act;
    r.cmd.coord_x     = COORD_W'(x);
    r.cmd.coord_y     = COORD_W'(y);
    r.cmd.pixel_value = PIXEL_W'(v);
    return r;
  endfunction

  // sample with the expected intensity written out
  function automatic stim_row_t check_row(input int unsigned x, input int unsigned y,
                                          input int unsigned want);
    stim_row_t r;
    r = item_row(ACT_SAMPLE, x, y, 0);
    r.typed = 1'b1;
    r.want  = INTENSITY_W'(want);
    return r;
  endfunction

  task automatic build_table();
    // a 2x2 image at reset geometry
    dir_tab.push_back(item_row(ACT_WRITE, 0, 0, 0));
    dir_tab.push_back(item_row(ACT_WRITE, 1, 0, 255));
    dir_tab.push_back(item_row(ACT_WRITE, 0, 1, 128));
    dir_tab.push_back(item_row(ACT_WRITE, 1, 1, 64));
    // reset registers: 1x, nearest, gain 1.0
    dir_tab.push_back(check_row(1, 0, 65280));
    dir_tab.push_back(check_row(0, 1, 32768));
    dir_tab.push_back(reg_row(REG_SOURCE_WIDTH, 2));
    dir_tab.push_back(reg_row(REG_SOURCE_HEIGHT, 2));
    // writes outside the image are dropped
    dir_tab.push_back(item_row(ACT_WRITE, 511, 511, 170));
    dir_tab.push_back(item_row(ACT_WRITE, 2, 0, 77));
    // far corner clamps to the last pixel
    dir_tab.push_back(check_row(511, 511, 16384));
    dir_tab.push_back(check_row(0, 0, 0));
    // gain extremes, saturation, zero gain, smallest gain
    dir_tab.push_back(reg_row(REG_INTENSITY_GAIN, 2048));
    dir_tab.push_back(check_row(1, 0, 130560));
    dir_tab.push_back(reg_row(REG_INTENSITY_GAIN, 4095));
    dir_tab.push_back(check_row(1, 0, INTENSITY_MAX));
    dir_tab.push_back(reg_row(REG_INTENSITY_GAIN, 0));
    dir_tab.push_back(check_row(1, 0, 0));
    dir_tab.push_back(reg_row(REG_INTENSITY_GAIN, 1));
    dir_tab.push_back(check_row(1, 0, 64));
    // bilinear at 2x, then 8x with edge clamping
    dir_tab.push_back(reg_row(REG_INTENSITY_GAIN, RST_GAIN));
    dir_tab.push_back(reg_row(REG_SAMPLE_MODE, MODE_BILINEAR));
    dir_tab.push_back(reg_row(REG_SCALE_LOG2, 1));
    dir_tab.push_back(item_row(ACT_SAMPLE, 1, 1, 0));
    dir_tab.push_back(item_row(ACT_SAMPLE, 2, 3, 0));
    dir_tab.push_back(item_row(ACT_SAMPLE, 0, 0, 255));
    dir_tab.push_back(reg_row(REG_SCALE_LOG2, 3));
    dir_tab.push_back(item_row(ACT_SAMPLE, 511, 0, 0));
    dir_tab.push_back(item_row(ACT_SAMPLE, 5, 3, 0));
    // zero width acts as one column
    dir_tab.push_back(reg_row(REG_SOURCE_WIDTH, 0));
    dir_tab.push_back(item_row(ACT_SAMPLE, 300, 9, 0));
    // unused index, and bits above each register's width are dropped
    dir_tab.push_back(reg_row(REG_UNUSED, 12'hfff));
    dir_tab.push_back(reg_row(REG_SCALE_LOG2, 12'hffc));
    dir_tab.push_back(reg_row(REG_SAMPLE_MODE, 12'hffe));
    dir_tab.push_back(reg_row(REG_SOURCE_WIDTH, 12'h082));
    dir_tab.push_back(check_row(1, 1, 16384));
    dir_tab.push_back(item_row(ACT_WRITE, 1, 1, 255));
    dir_tab.push_back(check_row(1, 1, 65280));
  endtask

  // ---------------------------------------------------------------
  // random phases
  // ---------------------------------------------------------------
  function automatic logic [PIXEL_W-1:0] rand_pixel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return PIXEL_W'($urandom_range(0, 255));
    endcase
  endfunction

  // now and then set bits above the register's width
  function automatic logic [CFG_DATA_W-1:0] with_junk(input int unsigned v, input int reg_w);
    logic [CFG_DATA_W-1:0] d;
    d = CFG_DATA_W'(v);
    if ($urandom_range(0, 3) == 0) begin
      d = d | (CFG_DATA_W'($urandom) << reg_w);
    end
    return d;
  endfunction

  // new settings, a fresh image over the whole active area, then samples
  // mixed with rewrites and dropped writes
  task automatic run_phase();
    int unsigned w, h, sz, lim_x, lim_y, n_samples, pick, wv, hv, gv, long_side, short_side;
    sample_req_t c;
    quiesce();
    cfg_put(REG_SCALE_LOG2, with_junk($urandom_range(0, 3), SCALE_REG_W));
    cfg_put(REG_SAMPLE_MODE, with_junk($urandom_range(0, 1), 1));
    if ($urandom_range(0, 4) == 0) begin
      // long thin strip, the only way to reach the full width or height cheaply
      case ($urandom_range(0, 2))
        0:       long_side = DEF_MAX_WIDTH;
        1:       long_side = 127;
        default: long_side = $urandom_range(9, 127);
      endcase
      short_side = $urandom_range(0, 2);
      if ($urandom_range(0, 1) == 0) begin
        wv = long_side;
        hv = short_side;
      end else begin
        wv = short_side;
        hv = long_side;
      end
    end else begin
      wv = $urandom_range(0, 8);
      hv = $urandom_range(0, 8);
    end
    cfg_put(REG_SOURCE_WIDTH, with_junk(wv, DIM_REG_W));
    cfg_put(REG_SOURCE_HEIGHT, with_junk(hv, DIM_REG_W));
    case ($urandom_range(0, 7))
      0:       gv = 0;
      1:       gv = 1;
      2:       gv = 2048;
      3:       gv = 4095;
      4, 5:    gv = RST_GAIN;
      default: gv = $urandom_range(1, 2048);
    endcase
    cfg_put(REG_INTENSITY_GAIN, CFG_DATA_W'(gv));
    steady = ($urandom_range(0, 3) == 0);

    w  = eff_span(width_cfg, DEF_MAX_WIDTH);
    h  = eff_span(height_cfg, DEF_MAX_HEIGHT);
    sz = 1 << scale_cfg;
    // output span plus one block beyond the edge
    lim_x = (w * sz + sz - 1 > 511) ? 511 : w * sz + sz - 1;
    lim_y = (h * sz + sz - 1 > 511) ? 511 : h * sz + sz - 1;

    // load every pixel that a sample can reach
    c.action = ACT_WRITE;
    for (int unsigned y = 0; y < h; y++) begin
      for (int unsigned x = 0; x < w; x++) begin
        c.coord_x     = COORD_W'(x);
        c.coord_y     = COORD_W'(y);
        c.pixel_value = rand_pixel();
        issue(c, 1'b0, '0);
        item_total++;
      end
    end

    n_samples = $urandom_range(16, 60);
    for (int unsigned k = 0; k < n_samples; k++) begin
      // occasional full drain in the middle of a phase
      if ($urandom_range(0, 39) == 0) begin
        quiesce();
      end
      pick = $urandom_range(0, 19);
      c.pixel_value = rand_pixel();
      if (pick < 2) begin
        // rewrite inside the image
        c.action  = ACT_WRITE;
        c.coord_x = COORD_W'($urandom_range(0, w - 1));
        c.coord_y = COORD_W'($urandom_range(0, h - 1));
        item_total++;
      end else if (pick == 2) begin
        // write outside the image, dropped by the block
        c.action = ACT_WRITE;
        if ($urandom_range(0, 1) == 0) begin
          c.coord_x = COORD_W'($urandom_range(w, 511));
          c.coord_y = COORD_W'($urandom_range(0, 511));
        end else begin
          c.coord_x = COORD_W'($urandom_range(0, 511));
          c.coord_y = COORD_W'($urandom_range(h, 511));
        end
        item_total++;
      end else begin
        c.action  = ACT_SAMPLE;
        c.coord_x = COORD_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 511)
                                                           : $urandom_range(0, lim_x));
        c.coord_y = COORD_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 511)
                                                           : $urandom_range(0, lim_y));
        item_total++;
      end
      issue(c, 1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------
  initial begin
    bit in_cfg;
    for (int i = 0; i < DEF_MAX_WIDTH*DEF_MAX_HEIGHT; i++) begin
      pix_mem[i] = '0;
    end
    build_table();
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed rows; register rows wait for the block to go idle first
    in_cfg = 1'b0;
    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_REG) begin
        if (!in_cfg) begin
          quiesce();
        end
        in_cfg = 1'b1;
        cfg_put(dir_tab[i].idx, dir_tab[i].data);
      end else begin
        in_cfg = 1'b0;
        issue(dir_tab[i].cmd, dir_tab[i].typed, dir_tab[i].want);
        item_total++;
      end
    end

    while (item_total < ITEM_TARGET) begin
      run_phase();
    end

    quiesce();
    if (mismatches == 0 && pending_samples.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
